// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Depends on nothing; the including scope must provide clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define CHD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("chd assertion failed");

// Checked at every rising edge, reset included.
`define CHD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("chd assertion failed");

`endif

// ===== sv/chd_pkg.sv =====
// Shared types, constants and the arctangent table of the direction core.
// Depends on nothing.
package chd_pkg;

  localparam int InBitsDef    = 16;
  localparam int OutBitsDef   = 16;
  localparam int CordicSteps  = 30;
  localparam int RootW        = 31;
  localparam int IterStages   = RootW;
  localparam int RemW         = 62;
  localparam int XyW          = 33;
  localparam int ResidW       = 32;
  localparam int TurnW        = 32;
  localparam int ProdW        = 62;
  localparam int QFrac        = 30;

  localparam logic signed [XyW-1:0] CordicStart = XyW'(652032874);
  localparam logic [RootW-1:0] OneQ30 = RootW'(1) << QFrac;

  typedef struct packed {
    logic [1:0]               quad;
    logic signed [XyW-1:0]    x;
    logic signed [XyW-1:0]    y;
    logic signed [ResidW-1:0] resid;
    logic [RemW-1:0]          rem_s;
    logic [RemW-1:0]          rem_h;
    logic [RootW-1:0]         root_s;
    logic [RootW-1:0]         root_h;
  } iter_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic signed [ResidW-1:0] atan_turn(input int unsigned idx);
    logic [ResidW-1:0] v;
    case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051D;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2E;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2F9;
      15: v = 32'h0000517C;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A2F;
      19: v = 32'h00000517;
      20: v = 32'h0000028B;
      21: v = 32'h00000145;
      22: v = 32'h000000A2;
      23: v = 32'h00000051;
      24: v = 32'h00000028;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000002;
      29: v = 32'h00000001;
      default: v = '0;
    endcase
    return signed'(v);
  endfunction

endpackage

// ===== sv/chd_iter_stage.sv =====
// One pipeline stage: one bit of both square roots and, if Step < CordicSteps, one CORDIC rotation step.
// Depends on chd_pkg.
module chd_iter_stage #(
  parameter int Step = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  chd_pkg::iter_t  d_i,
  output logic            vld_o,
  output chd_pkg::iter_t  q_o
);

  localparam int AtanIdx = (Step < chd_pkg::CordicSteps) ? Step : 0;
  localparam int Bit     = chd_pkg::RootW - 1 - Step;
  localparam logic signed [chd_pkg::ResidW-1:0] Atan = chd_pkg::atan_turn(AtanIdx);

  logic signed [chd_pkg::XyW-1:0] xs, ys;
  logic [chd_pkg::RemW-1:0]       inc_s, inc_h;
  chd_pkg::iter_t                 stg_d, stg_q;
  logic                           vld_q;

  // Shifts of signed values round toward minus infinity.
  assign xs = d_i.x >>> AtanIdx;
  assign ys = d_i.y >>> AtanIdx;

  // Adding this bit to the root grows its square by 2*root*2^b + 2^(2b).
  assign inc_s = (chd_pkg::RemW'(d_i.root_s) << (Bit + 1))
               + (chd_pkg::RemW'(1) << (2 * Bit));
  assign inc_h = (chd_pkg::RemW'(d_i.root_h) << (Bit + 1))
               + (chd_pkg::RemW'(1) << (2 * Bit));

  always_comb begin
    stg_d = d_i;
    if (Step < chd_pkg::CordicSteps) begin
      if (!d_i.resid[chd_pkg::ResidW-1]) begin
        stg_d.x     = d_i.x - ys;
        stg_d.y     = d_i.y + xs;
        stg_d.resid = d_i.resid - Atan;
      end else begin
        stg_d.x     = d_i.x + ys;
        stg_d.y     = d_i.y - xs;
        stg_d.resid = d_i.resid + Atan;
      end
    end
    if (d_i.rem_s >= inc_s) begin
      stg_d.rem_s  = d_i.rem_s - inc_s;
      stg_d.root_s = d_i.root_s | (chd_pkg::RootW'(1) << Bit);
    end
    if (d_i.rem_h >= inc_h) begin
      stg_d.rem_h  = d_i.rem_h - inc_h;
      stg_d.root_h = d_i.root_h | (chd_pkg::RootW'(1) << Bit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stg_q <= stg_d;
    end
  end

  assign vld_o = vld_q;
  assign q_o   = stg_q;

endmodule

// ===== sv/chd_out_stage.sv =====
// Quadrant mapping, the two spread products, rounding and saturation.
// Depends on chd_pkg; three register stages, the last one drives the outputs.
module chd_out_stage #(
  parameter int OUT_BITS = chd_pkg::OutBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  chd_pkg::iter_t             d_i,
  output logic                       vld_o,
  output logic signed [OUT_BITS-1:0] dir_x_o,
  output logic signed [OUT_BITS-1:0] dir_y_o,
  output logic [OUT_BITS-2:0]        dir_z_o
);

  localparam int Frac = OUT_BITS - 1;
  localparam int Sh   = 60 - Frac;
  localparam int SumW = chd_pkg::ProdW + 1;
  localparam logic [SumW-1:0] Half = SumW'(1) << (Sh - 1);
  localparam logic [SumW-1:0] Top  = (SumW'(1) << Frac) - SumW'(1);

  localparam int RW = chd_pkg::RootW;

  // Stage A: clamped and mapped unit vector.
  logic [RW-1:0] c_w, s_w, mx_d, my_d;
  logic          nx_d, ny_d;
  logic [RW-1:0] mx_q, my_q, spr_a_q, hgt_a_q;
  logic          nx_a_q, ny_a_q, vld_a_q;

  // Stage B: products.
  logic [chd_pkg::ProdW-1:0] px_q, py_q;
  logic [RW-1:0]             hgt_b_q;
  logic                      nx_b_q, ny_b_q, vld_b_q;

  // Stage C: rounded outputs.
  logic [SumW-1:0]           rx, ry, rz;
  logic [Frac-1:0]           sx, sy, sz;
  logic signed [OUT_BITS-1:0] dx_d, dy_d, dx_q, dy_q;
  logic [OUT_BITS-2:0]       dz_q;
  logic                      vld_c_q;

  function automatic logic [RW-1:0] clamp_unit(input logic signed [chd_pkg::XyW-1:0] v);
    if (v[chd_pkg::XyW-1]) begin
      return '0;
    end else if (v > signed'(chd_pkg::XyW'(chd_pkg::OneQ30))) begin
      return chd_pkg::OneQ30;
    end
    return v[RW-1:0];
  endfunction

  assign c_w = clamp_unit(d_i.x);
  assign s_w = clamp_unit(d_i.y);

  always_comb begin
    case (d_i.quad)
      2'd0: begin mx_d = c_w; nx_d = 1'b0; my_d = s_w; ny_d = 1'b0; end
      2'd1: begin mx_d = s_w; nx_d = 1'b1; my_d = c_w; ny_d = 1'b0; end
      2'd2: begin mx_d = c_w; nx_d = 1'b1; my_d = s_w; ny_d = 1'b1; end
      default: begin mx_d = s_w; nx_d = 1'b0; my_d = c_w; ny_d = 1'b1; end
    endcase
  end

  // Round half up on the Q.60 magnitude, then saturate just below one.
  assign rx = (SumW'(px_q) + Half) >> Sh;
  assign ry = (SumW'(py_q) + Half) >> Sh;
  assign rz = (SumW'({hgt_b_q, chd_pkg::QFrac'(0)}) + Half) >> Sh;
  assign sx = (rx > Top) ? Top[Frac-1:0] : rx[Frac-1:0];
  assign sy = (ry > Top) ? Top[Frac-1:0] : ry[Frac-1:0];
  assign sz = (rz > Top) ? Top[Frac-1:0] : rz[Frac-1:0];
  assign dx_d = nx_b_q ? -signed'({1'b0, sx}) : signed'({1'b0, sx});
  assign dy_d = ny_b_q ? -signed'({1'b0, sy}) : signed'({1'b0, sy});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx_q    <= mx_d;
      my_q    <= my_d;
      nx_a_q  <= nx_d;
      ny_a_q  <= ny_d;
      spr_a_q <= d_i.root_s;
      hgt_a_q <= d_i.root_h;
      px_q    <= chd_pkg::ProdW'(mx_q) * chd_pkg::ProdW'(spr_a_q);
      py_q    <= chd_pkg::ProdW'(my_q) * chd_pkg::ProdW'(spr_a_q);
      hgt_b_q <= hgt_a_q;
      nx_b_q  <= nx_a_q;
      ny_b_q  <= ny_a_q;
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      dz_q    <= sz;
    end
  end

  assign vld_o   = vld_c_q;
  assign dir_x_o = dx_q;
  assign dir_y_o = dy_q;
  assign dir_z_o = dz_q;

endmodule

// ===== sv/cosine_hemisphere_direction_core.sv =====
// Channel | direction | beat contents
// in      | sink      | u_angle_i, u_radius_i
// out     | source    | dir_x_o, dir_y_o, dir_z_o
// One beat may enter every cycle while no result waits on a stalled output; a beat
// passes through 31 stages that each do one bit of both square roots, and one CORDIC
// step in all but the last, then through mapping, multiply and rounding stages.
// Reset clears only the valid bits. A stalled output freezes the whole
// pipeline, so in_stall_o follows out_stall_i while a result is waiting.
module cosine_hemisphere_direction_core #(
  parameter int IN_BITS  = chd_pkg::InBitsDef,
  parameter int OUT_BITS = chd_pkg::OutBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [IN_BITS-1:0]         u_angle_i,
  input  logic [IN_BITS-1:0]         u_radius_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [OUT_BITS-1:0] dir_x_o,
  output logic signed [OUT_BITS-1:0] dir_y_o,
  output logic [OUT_BITS-2:0]        dir_z_o
);

  localparam int N = chd_pkg::IterStages;

  logic                en;
  logic [chd_pkg::TurnW-1:0] turn;
  chd_pkg::iter_t      stg [0:N];
  logic                vld [0:N];

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  assign turn = chd_pkg::TurnW'(u_angle_i) << (chd_pkg::TurnW - IN_BITS);

  always_comb begin
    stg[0].quad   = turn[chd_pkg::TurnW-1 -: 2];
    stg[0].x      = chd_pkg::CordicStart;
    stg[0].y      = '0;
    stg[0].resid  = signed'({2'b00, turn[chd_pkg::TurnW-3:0]});
    stg[0].rem_s  = chd_pkg::RemW'(u_radius_i) << (60 - IN_BITS);
    stg[0].rem_h  = ((chd_pkg::RemW'(1) << IN_BITS) - chd_pkg::RemW'(u_radius_i))
                    << (60 - IN_BITS);
    stg[0].root_s = '0;
    stg[0].root_h = '0;
  end
  assign vld[0] = in_valid_i;

  for (genvar k = 0; k < N; k++) begin : g_iter
    chd_iter_stage #(.Step(k)) u_iter (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (vld[k]),
      .d_i    (stg[k]),
      .vld_o  (vld[k+1]),
      .q_o    (stg[k+1])
    );
  end

  chd_out_stage #(.OUT_BITS(OUT_BITS)) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (vld[N]),
    .d_i     (stg[N]),
    .vld_o   (out_valid_o),
    .dir_x_o (dir_x_o),
    .dir_y_o (dir_y_o),
    .dir_z_o (dir_z_o)
  );

endmodule

// ===== sv/chd_checker.sv =====
// Port-level checks of the direction core, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module chd_checker #(
  parameter int IN_BITS  = 16,
  parameter int OUT_BITS = 16
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic [IN_BITS-1:0]         u_angle_i,
  input logic [IN_BITS-1:0]         u_radius_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic signed [OUT_BITS-1:0] dir_x_o,
  input logic signed [OUT_BITS-1:0] dir_y_o,
  input logic [OUT_BITS-2:0]        dir_z_o
);

  localparam logic [OUT_BITS-1:0] MinVal = {1'b1, {(OUT_BITS-1){1'b0}}};

  property p_out_hold;
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(dir_x_o) && $stable(dir_y_o) && $stable(dir_z_o);
  endproperty

  property p_in_hold;
    in_valid_i && in_stall_o |=>
      in_valid_i && $stable(u_angle_i) && $stable(u_radius_i);
  endproperty

  // A waiting result keeps its beat until it is taken.
  `CHD_ASSERT(a_out_hold, p_out_hold)
  // A held-back input beat stays on the inputs until it is taken.
  `CHD_ASSERT(a_in_hold, p_in_hold)
  // The input is held back exactly when a result waits.
  `CHD_ASSERT_ALWAYS(a_stall_link, in_stall_o == (out_valid_o && out_stall_i))
  // Saturation never yields the most negative code.
  `CHD_ASSERT(a_x_sat, out_valid_o |-> dir_x_o != MinVal)
  `CHD_ASSERT(a_y_sat, out_valid_o |-> dir_y_o != MinVal)

endmodule

bind cosine_hemisphere_direction_core chd_checker #(
  .IN_BITS  (IN_BITS),
  .OUT_BITS (OUT_BITS)
) u_chd_checker (.*);

// ===== dv/cosine_hemisphere_direction_core_test.sv =====
// Self-checking bench for the cosine-weighted hemisphere direction core.
// Depends on chd_pkg and cosine_hemisphere_direction_core; drives directed and random beats
// with random gaps and output stalls; checks results by bit-true prediction or set values.
module cosine_hemisphere_direction_core_test;

  localparam int InW      = chd_pkg::InBitsDef;
  localparam int OutW     = chd_pkg::OutBitsDef;
  localparam int NumRand  = 1500;
  localparam int IdleMax  = 5000;
  localparam int Latency  = 34;
  localparam logic [OutW-2:0] ZMax = '1;

  typedef struct packed {
    logic signed [OutW-1:0] x;
    logic signed [OutW-1:0] y;
    logic [OutW-2:0]        z;
  } dir_t;

  typedef struct {
    logic [InW-1:0] ang;
    logic [InW-1:0] rad;
    bit             typed;
    dir_t           want;
  } stim_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [InW-1:0]         u_angle_i = '0;
  logic [InW-1:0]         u_radius_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic signed [OutW-1:0] dir_x_o;
  logic signed [OutW-1:0] dir_y_o;
  logic [OutW-2:0]        dir_z_o;

  dir_t pending_dirs[$];
  int   mismatches = 0;
  int   idle_cycles = 0;

  cosine_hemisphere_direction_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .u_angle_i  (u_angle_i),
    .u_radius_i (u_radius_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .dir_x_o    (dir_x_o),
    .dir_y_o    (dir_y_o),
    .dir_z_o    (dir_z_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Rounds a Q.60 magnitude to the output fraction, halves upwards, and saturates.
  function automatic longint unsigned round_q60(longint unsigned mag);
    longint unsigned r;
    r = (mag + (64'd1 << (60 - OutW))) >> (61 - OutW);
    return (r > ZMax) ? longint'(ZMax) : r;
  endfunction

  function automatic logic [OutW-1:0] scale_signed(longint unit, longint unsigned spread);
    longint unsigned r;
    r = round_q60(longint'(unit < 0 ? -unit : unit) * spread);
    return (unit < 0) ? OutW'(-r) : OutW'(r);
  endfunction

  function automatic dir_t predict_dir(logic [InW-1:0] ang, logic [InW-1:0] rad);
    logic [31:0]     turn;
    longint          cx, cy, nx, resid, c, s, ux, uy;
    longint unsigned spread, height;
    dir_t            d;
    turn = 32'(ang) << (32 - InW);
    resid = longint'(turn[29:0]);
    cx = 652032874;
    cy = 0;
    for (int i = 0; i < chd_pkg::CordicSteps; i++) begin
      if (resid >= 0) begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        resid -= longint'(chd_pkg::atan_turn(i));
      end else begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        resid += longint'(chd_pkg::atan_turn(i));
      end
      cx = nx;
    end
    c = (cx < 0) ? 0 : (cx > (64'sd1 << 30)) ? (64'sd1 << 30) : cx;
    s = (cy < 0) ? 0 : (cy > (64'sd1 << 30)) ? (64'sd1 << 30) : cy;
    case (turn[31:30])
      2'd0: begin ux = c;  uy = s;  end
      2'd1: begin ux = -s; uy = c;  end
      2'd2: begin ux = -c; uy = -s; end
      default: begin ux = s; uy = -c; end
    endcase
    spread = int_sqrt(longint'(rad) << (60 - InW));
    height = int_sqrt(((64'd1 << InW) - rad) << (60 - InW));
    d.x = scale_signed(ux, spread);
    d.y = scale_signed(uy, spread);
    d.z = (OutW-1)'(round_q60(height << 30));
    return d;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
    mismatches++;
  endtask

  // Output side: compare each result beat with the oldest expectation.
  always @(posedge clk_i) begin
    dir_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_dirs.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = pending_dirs.pop_front();
        if (dir_x_o !== want.x) report_mismatch("dir_x", dir_x_o, want.x);
        if (dir_y_o !== want.y) report_mismatch("dir_y", dir_y_o, want.y);
        if (dir_z_o !== want.z) report_mismatch("dir_z", dir_z_o, want.z);
      end
    end
  end

  // Receiver stalls in stretches: sometimes never, sometimes often, sometimes in long runs.
  always @(posedge clk_i) begin
    static int mode = 0;
    static int mode_left = 0;
    if (mode_left == 0) begin
      mode = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 200);
    end
    mode_left--;
    case (mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= ($urandom_range(0, 15) < 12);
    endcase
  end

  // Watchdog on cycles with no beat moving on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleMax) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_beat(logic [InW-1:0] ang, logic [InW-1:0] rad, bit typed, dir_t want);
    int gap;
    u_angle_i  <= ang;
    u_radius_i <= rad;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_dirs.push_back(typed ? want : predict_dir(ang, rad));
    // Bursts: most beats follow back to back, some leave a gap.
    if ($urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      u_angle_i  <= InW'($urandom);
      u_radius_i <= InW'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [InW-1:0] pick_field();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return InW'($urandom_range(0, 3)) << (InW - 2);
      3: return InW'($urandom_range(0, 15));
      4: return ~InW'($urandom_range(0, 15));
      default: return InW'($urandom);
    endcase
  endfunction

  initial begin
    stim_row_t rows[$];
    dir_t none;
    none = '0;
    // Zero radius gives a straight-up direction whatever the angle.
    rows.push_back('{16'h0000, 16'h0000, 1'b1, '{16'sd0, 16'sd0, ZMax}});
    rows.push_back('{16'hFFFF, 16'h0000, 1'b1, '{16'sd0, 16'sd0, ZMax}});
    rows.push_back('{16'h4000, 16'h0000, 1'b1, '{16'sd0, 16'sd0, ZMax}});
    rows.push_back('{16'hC000, 16'h0000, 1'b1, '{16'sd0, 16'sd0, ZMax}});
    // Exact quadrant angles at full and half radius.
    rows.push_back('{16'h0000, 16'hFFFF, 1'b0, none});
    rows.push_back('{16'h4000, 16'hFFFF, 1'b0, none});
    rows.push_back('{16'h8000, 16'hFFFF, 1'b0, none});
    rows.push_back('{16'hC000, 16'hFFFF, 1'b0, none});
    rows.push_back('{16'h0000, 16'h8000, 1'b0, none});
    rows.push_back('{16'h4000, 16'h8000, 1'b0, none});
    rows.push_back('{16'h8000, 16'h8000, 1'b0, none});
    rows.push_back('{16'hC000, 16'h8000, 1'b0, none});
    // Tiny radius, then other edge angles and radii.
    rows.push_back('{16'h8000, 16'h0001, 1'b0, none});
    rows.push_back('{16'hC000, 16'h0001, 1'b0, none});
    rows.push_back('{16'h6000, 16'h0001, 1'b0, none});
    rows.push_back('{16'hFFFF, 16'hFFFF, 1'b0, none});
    rows.push_back('{16'h3FFF, 16'hFFFF, 1'b0, none});
    rows.push_back('{16'h2000, 16'h4000, 1'b0, none});
    rows.push_back('{16'hA000, 16'hFFFE, 1'b0, none});
    rows.push_back('{16'h0001, 16'h0002, 1'b0, none});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_beat(rows[i].ang, rows[i].rad, rows[i].typed, rows[i].want);
    for (int n = 0; n < NumRand; n++) send_beat(pick_field(), pick_field(), 1'b0, none);
    in_valid_i <= 1'b0;

    while (pending_dirs.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/chd_pkg.sv
sv/chd_iter_stage.sv
sv/chd_out_stage.sv
sv/cosine_hemisphere_direction_core.sv
sv/chd_checker.sv
dv/cosine_hemisphere_direction_core_test.sv
